>>> rtl/rfb_pkg.sv
`default_nettype none

package rfb_pkg;

  // Register map of the configuration port.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic REG_STAGE_SPAN = 1'b0;
  localparam logic [10:0] SPAN_RESET = 11'd1;

  // Twiddle modes of the complex multiplier.
  localparam logic [1:0] MUL_TW = 2'd0;
  localparam logic [1:0] MUL_ONE = 2'd1;
  localparam logic [1:0] MUL_NEGJ = 2'd2;

  // Rounding offset for the Q2.30 to Q1.15 step.
  localparam logic signed [33:0] RND_HALF = 34'sd16384;

  // Packed Q1.15 complex value, real part in the upper half.
  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
  } cplx_t;

  typedef struct packed {
    logic f;
    logic signed [15:0] v;
  } sat_t;

  typedef struct packed {
    logic f;
    cplx_t v;
  } csat_t;

  typedef struct packed {
    logic [31:0] point_a;
    logic [31:0] point_b;
    logic [31:0] point_c;
    logic [31:0] point_d;
    logic [31:0] twiddle_outer;
    logic [31:0] twiddle_even;
    logic [31:0] twiddle_odd;
    logic [9:0] butterfly_index;
  } in_word_t;

  typedef struct packed {
    logic [31:0] sum_even;
    logic [31:0] sum_odd;
    logic [31:0] diff_even;
    logic [31:0] diff_odd;
    logic [11:0] base_address;
    logic saturated;
  } out_word_t;

  // Clip a wide signed value to 16 bits and report clipping.
  function automatic sat_t sat16(logic signed [19:0] v);
    sat_t s;
    if (v > 20'sd32767) begin
      s.v = 16'sh7fff;
      s.f = 1'b1;
    end else if (v < -20'sd32768) begin
      s.v = 16'sh8000;
      s.f = 1'b1;
    end else begin
      s.v = v[15:0];
      s.f = 1'b0;
    end
    return s;
  endfunction

  // Saturating complex add or subtract.
  function automatic csat_t csum(cplx_t x, cplx_t y, logic sub);
    logic signed [19:0] xr;
    logic signed [19:0] xi;
    logic signed [19:0] yr;
    logic signed [19:0] yi;
    sat_t sr;
    sat_t si;
    csat_t o;
    xr = 20'($signed(x.re));
    xi = 20'($signed(x.im));
    yr = 20'($signed(y.re));
    yi = 20'($signed(y.im));
    sr = sat16(sub ? (xr - yr) : (xr + yr));
    si = sat16(sub ? (xi - yi) : (xi + yi));
    o.v.re = sr.v;
    o.v.im = si.v;
    o.f = sr.f | si.f;
    return o;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rfb_cmul.sv
`default_nettype none

// Two-stage complex multiplier: partial products, then sum, round and clip.
module rfb_cmul (
  input  wire              clk,
  input  wire              en_a,
  input  wire              en_b,
  input  rfb_pkg::cplx_t   x_in,
  input  rfb_pkg::cplx_t   w_in,
  input  wire [1:0]        mode_in,
  output rfb_pkg::cplx_t   y_out,
  output logic             sat_out
);

  rfb_pkg::cplx_t x_r;
  logic [1:0] mode_r;
  logic signed [31:0] p_rr_r;
  logic signed [31:0] p_ii_r;
  logic signed [31:0] p_ri_r;
  logic signed [31:0] p_ir_r;

  logic signed [32:0] re_sum;
  logic signed [32:0] im_sum;
  logic signed [33:0] re_rnd;
  logic signed [33:0] im_rnd;
  rfb_pkg::sat_t re_sat;
  rfb_pkg::sat_t im_sat;
  rfb_pkg::sat_t neg_sat;
  rfb_pkg::cplx_t y_nxt;
  logic sat_nxt;
  rfb_pkg::cplx_t y_r;
  logic sat_r;

  // First stage: the four partial products.
  always_ff @(posedge clk) begin
    if (en_a) begin
      x_r <= x_in;
      mode_r <= mode_in;
      p_rr_r <= $signed(x_in.re) * $signed(w_in.re);
      p_ii_r <= $signed(x_in.im) * $signed(w_in.im);
      p_ri_r <= $signed(x_in.re) * $signed(w_in.im);
      p_ir_r <= $signed(x_in.im) * $signed(w_in.re);
    end
  end

  // Second stage: exact sums, round half up, clip to Q1.15; or pass x, or x times -j.
  always_comb begin
    re_sum = 33'(p_rr_r) - 33'(p_ii_r);
    im_sum = 33'(p_ri_r) + 33'(p_ir_r);
    re_rnd = 34'(re_sum) + rfb_pkg::RND_HALF;
    im_rnd = 34'(im_sum) + rfb_pkg::RND_HALF;
    re_sat = rfb_pkg::sat16({re_rnd[33], re_rnd[33:15]});
    im_sat = rfb_pkg::sat16({im_rnd[33], im_rnd[33:15]});
    neg_sat = rfb_pkg::sat16(-{{4{x_r.re[15]}}, x_r.re});
    case (mode_r)
      rfb_pkg::MUL_TW: begin
        y_nxt.re = re_sat.v;
        y_nxt.im = im_sat.v;
        sat_nxt = re_sat.f | im_sat.f;
      end
      rfb_pkg::MUL_NEGJ: begin
        y_nxt.re = x_r.im;
        y_nxt.im = neg_sat.v;
        sat_nxt = neg_sat.f;
      end
      default: begin
        y_nxt = x_r;
        sat_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      y_r <= y_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign y_out = y_r;
  assign sat_out = sat_r;

endmodule

`default_nettype wire

>>> rtl/radix4_fft_butterfly_stage_top.sv
`default_nettype none

// Channel  Handshake           Payload
// in_      in_valid/in_ready   in_data  (rfb_pkg::in_word_t)
// out_     out_valid/out_ready out_data (rfb_pkg::out_word_t)
// cfg      psel/penable/pready paddr, pwdata, prdata (APB write/read)
//
// One butterfly word per cycle unless out_ready stalls; six register stages from acceptance to out_valid.
// Latency is set by the two two-stage complex multipliers and the two add stages.
// Reset (rst_n low, synchronous) empties the pipeline and sets the span to one.
// Each stage advances when it is empty or the next stage advances, so bubbles
// close up under a stall and in_ready stays high while any stage is empty.
module radix4_fft_butterfly_stage_top #(
  parameter int unsigned TRANSFORM_SIZE = 4096
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  rfb_pkg::in_word_t                in_data,
  output logic                             out_valid,
  input  wire                              out_ready,
  output rfb_pkg::out_word_t               out_data,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [rfb_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire [31:0]                       pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam logic [9:0] IDX_MASK = 10'((TRANSFORM_SIZE / 4) - 1);

  logic [10:0] span_r;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic en1, en2, en3, en4, en5, en6;

  logic [9:0] idx;
  logic [9:0] span_mask;
  logic [9:0] k_low;
  logic [11:0] base_nxt;
  logic one_nxt;
  logic [1:0] mode_cd;
  logic [1:0] mode_r2;
  logic [1:0] mode_r3;

  rfb_pkg::cplx_t a1_r, b1_r, w0_1_r, w1_1_r;
  rfb_pkg::cplx_t a2_r, b2_r, w0_2_r, w1_2_r;
  logic [11:0] base1_r, base2_r, base3_r, base4_r, base5_r;
  logic one1_r, one2_r, one3_r, one4_r, one5_r, one6_r;

  rfb_pkg::cplx_t tc, td;
  logic sat_c, sat_d;
  rfb_pkg::csat_t r0_nxt, r1_nxt, r2_nxt, r3_nxt;
  rfb_pkg::cplx_t r0_3_r, r1_3_r, r2_3_r, r3_3_r, w0_3_r, w1_3_r;
  logic flag3_nxt, flag3_r, flag4_r, flag5_r;
  rfb_pkg::cplx_t r0_4_r, r1_4_r, r0_5_r, r1_5_r;

  rfb_pkg::cplx_t t2, t3;
  logic sat_2, sat_3;
  rfb_pkg::csat_t s0, s1, d0, d1;
  rfb_pkg::out_word_t out_nxt;
  rfb_pkg::out_word_t out_r;

  // Configuration register write and readback.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r <= rfb_pkg::SPAN_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == rfb_pkg::REG_STAGE_SPAN)) begin
      span_r <= pwdata[10:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == rfb_pkg::REG_STAGE_SPAN) begin
      prdata = {21'd0, span_r};
    end
  end

  // Stage enables: a stage loads when empty or when its successor moves.
  assign en6 = !v6_r || out_ready;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  // Stockham base address and the span-of-one flag for the incoming word.
  always_comb begin
    idx = in_data.butterfly_index & IDX_MASK;
    span_mask = span_r[9:0] - 10'd1;
    k_low = idx & span_mask;
    base_nxt = {idx & ~span_mask, 2'b00} + {2'b00, k_low};
    one_nxt = (span_r == 11'd1);
    mode_cd = one_nxt ? rfb_pkg::MUL_ONE : rfb_pkg::MUL_TW;
    mode_r2 = one3_r ? rfb_pkg::MUL_ONE : rfb_pkg::MUL_TW;
    mode_r3 = one3_r ? rfb_pkg::MUL_NEGJ : rfb_pkg::MUL_TW;
  end

  // Stages one and two: c and d through the outer twiddle, or unchanged for a span of one.
  rfb_cmul u_mul_c (
    .clk     (clk),
    .en_a    (en1),
    .en_b    (en2),
    .x_in    (rfb_pkg::cplx_t'(in_data.point_c)),
    .w_in    (rfb_pkg::cplx_t'(in_data.twiddle_outer)),
    .mode_in (mode_cd),
    .y_out   (tc),
    .sat_out (sat_c)
  );

  rfb_cmul u_mul_d (
    .clk     (clk),
    .en_a    (en1),
    .en_b    (en2),
    .x_in    (rfb_pkg::cplx_t'(in_data.point_d)),
    .w_in    (rfb_pkg::cplx_t'(in_data.twiddle_outer)),
    .mode_in (mode_cd),
    .y_out   (td),
    .sat_out (sat_d)
  );

  always_ff @(posedge clk) begin
    if (en1) begin
      a1_r <= rfb_pkg::cplx_t'(in_data.point_a);
      b1_r <= rfb_pkg::cplx_t'(in_data.point_b);
      w0_1_r <= rfb_pkg::cplx_t'(in_data.twiddle_even);
      w1_1_r <= rfb_pkg::cplx_t'(in_data.twiddle_odd);
      base1_r <= base_nxt;
      one1_r <= one_nxt;
    end
    if (en2) begin
      a2_r <= a1_r;
      b2_r <= b1_r;
      w0_2_r <= w0_1_r;
      w1_2_r <= w1_1_r;
      base2_r <= base1_r;
      one2_r <= one1_r;
    end
  end

  // Stage three: the two radix-2 pairs with saturation.
  always_comb begin
    r0_nxt = rfb_pkg::csum(a2_r, tc, 1'b0);
    r1_nxt = rfb_pkg::csum(a2_r, tc, 1'b1);
    r2_nxt = rfb_pkg::csum(b2_r, td, 1'b0);
    r3_nxt = rfb_pkg::csum(b2_r, td, 1'b1);
    flag3_nxt = sat_c | sat_d | r0_nxt.f | r1_nxt.f | r2_nxt.f | r3_nxt.f;
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      r0_3_r <= r0_nxt.v;
      r1_3_r <= r1_nxt.v;
      r2_3_r <= r2_nxt.v;
      r3_3_r <= r3_nxt.v;
      w0_3_r <= w0_2_r;
      w1_3_r <= w1_2_r;
      base3_r <= base2_r;
      one3_r <= one2_r;
      flag3_r <= flag3_nxt;
    end
  end

  // Stages four and five: inner twiddles, or one and -j for a span of one.
  rfb_cmul u_mul_r2 (
    .clk     (clk),
    .en_a    (en4),
    .en_b    (en5),
    .x_in    (r2_3_r),
    .w_in    (w0_3_r),
    .mode_in (mode_r2),
    .y_out   (t2),
    .sat_out (sat_2)
  );

  rfb_cmul u_mul_r3 (
    .clk     (clk),
    .en_a    (en4),
    .en_b    (en5),
    .x_in    (r3_3_r),
    .w_in    (w1_3_r),
    .mode_in (mode_r3),
    .y_out   (t3),
    .sat_out (sat_3)
  );

  always_ff @(posedge clk) begin
    if (en4) begin
      r0_4_r <= r0_3_r;
      r1_4_r <= r1_3_r;
      base4_r <= base3_r;
      one4_r <= one3_r;
      flag4_r <= flag3_r;
    end
    if (en5) begin
      r0_5_r <= r0_4_r;
      r1_5_r <= r1_4_r;
      base5_r <= base4_r;
      one5_r <= one4_r;
      flag5_r <= flag4_r;
    end
  end

  // Stage six: final sums and differences into the output register.
  always_comb begin
    s0 = rfb_pkg::csum(r0_5_r, t2, 1'b0);
    s1 = rfb_pkg::csum(r1_5_r, t3, 1'b0);
    d0 = rfb_pkg::csum(r0_5_r, t2, 1'b1);
    d1 = rfb_pkg::csum(r1_5_r, t3, 1'b1);
    out_nxt.sum_even = s0.v;
    out_nxt.sum_odd = s1.v;
    out_nxt.diff_even = d0.v;
    out_nxt.diff_odd = d1.v;
    out_nxt.base_address = base5_r;
    out_nxt.saturated = flag5_r | sat_2 | sat_3 | s0.f | s1.f | d0.f | d1.f;
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      out_r <= out_nxt;
      one6_r <= one5_r;
    end
  end

  assign out_valid = v6_r;
  assign out_data = out_r;

`ifndef ASSERT_OFF
  // A drained output side never blocks the input.
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  // A word in stage five that may advance reaches the output.
  a_stage5_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && en6) |=> out_valid)
    else $error("word lost between stage five and output");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // With a span of one the base address is a multiple of four.
  a_span_one_base: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && one6_r) |-> (out_data.base_address[1:0] == 2'b00))
    else $error("bad base address for span of one");
`endif

endmodule

`default_nettype wire
